// ----- hw/rtl/bsc_pkg.sv -----
// Shared types and codes for the Banker's algorithm safety check unit.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

   // Width of the process number carried in a result.
   localparam int PID_W = 4;

   typedef enum logic [1:0] {
      OP_LOAD_PROC  = 2'd0,
      OP_LOAD_AVAIL = 2'd1,
      OP_RUN        = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_NUM_PROCESSES = 1'b0,
      CSR_NUM_RESOURCES = 1'b1
   } csr_idx_type;

   typedef enum logic {
      ALU_SUB = 1'b0,
      ALU_ADD = 1'b1
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_PROC,
      ST_CHECK_RD,
      ST_CHECK,
      ST_GRANT_RD,
      ST_GRANT,
      ST_NEXT,
      ST_VERDICT
   } seq_state_type;

   typedef struct packed {
      logic [PID_W-1:0] process_id;
      logic             is_verdict;
      logic             system_safe;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bsc_table.sv -----
// Allocation and need memory: one entry per process and resource.
// Computes the clamped need on a load. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_table #(
   parameter int UW    = 16,
   parameter int DEPTH = 160,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [UW-1:0] wr_alloc,
   input  wire logic [UW-1:0] wr_max,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [UW-1:0] rd_alloc,
   output logic      [UW-1:0] rd_need
);
   import bsc_pkg::*;

   // Each word holds the allocation in the upper half and the need in the lower half.
   logic [2*UW-1:0] mem [DEPTH];
   logic [2*UW-1:0] rd_data_ff;
   logic [UW-1:0]   need_val;

   assign need_val = (wr_max > wr_alloc) ? (wr_max - wr_alloc) : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_alloc, need_val};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_alloc = rd_data_ff[2*UW-1:UW];
   assign rd_need  = rd_data_ff[UW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/bsc_alu.sv -----
// Shared arithmetic unit: one adder serves both the need compare and the
// saturating allocation add. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_alu #(
   parameter int UW = 16
) (
   input  wire bsc_pkg::alu_op_type op,
   input  wire logic [UW-1:0]       a,
   input  wire logic [UW-1:0]       b,
   output logic                     less,
   output logic [UW-1:0]            sat_sum
);
   import bsc_pkg::*;

   logic          sub;
   logic [UW-1:0] operand;
   logic [UW:0]   sum;

   assign sub     = (op == ALU_SUB);
   assign operand = sub ? ~b : b;
   assign sum     = {1'b0, a} + {1'b0, operand} + {{UW{1'b0}}, sub};

   // On subtract the carry out means a >= b; on add it means overflow.
   assign less    = sub & ~sum[UW];
   assign sat_sum = sum[UW] ? {UW{1'b1}} : sum[UW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/bsc_seq.sv -----
// Run sequencer: working vector, stored availability, done marks and the
// pass loop over processes and resources. Depends on bsc_pkg and bsc_alu.
`timescale 1ns / 1ps
`default_nettype none

module bsc_seq #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 10,
   parameter int UW        = 16,
   parameter int AW        = 8,
   parameter int NW        = 5,
   parameter int RCW       = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             run_accept,
   input  wire logic             avail_we,
   input  wire logic [3:0]       avail_idx,
   input  wire logic [UW-1:0]    avail_val,
   input  wire logic [NW-1:0]    n_eff,
   input  wire logic [RCW-1:0]   r_eff,
   output logic                  busy,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  wire logic [UW-1:0]    rd_alloc,
   input  wire logic [UW-1:0]    rd_need,
   output logic                  rsp_valid,
   output bsc_pkg::rsp_type      rsp
);
   import bsc_pkg::*;

   localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

   seq_state_type        state_ff, state_in;
   logic [PW-1:0]        p_ff, p_in;
   logic [RW-1:0]        q_ff, q_in;
   logic [NW-1:0]        granted_ff, granted_in;
   logic                 pass_ff, pass_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [UW-1:0]        work_ff [MAX_RES];
   logic [UW-1:0]        avail_ff [MAX_RES];
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic          work_we;
   logic [UW-1:0] work_wdata;
   logic          emit_grant, emit_verdict;
   logic          q_last, p_last, all_done;
   alu_op_type    alu_op;
   logic          alu_less;
   logic [UW-1:0] alu_sum;

   assign q_last   = (RCW'(q_ff) + RCW'(1)) == r_eff;
   assign p_last   = (NW'(p_ff) + NW'(1)) == n_eff;
   assign all_done = granted_ff >= n_eff;
   assign alu_op   = (state_ff == ST_CHECK) ? ALU_SUB : ALU_ADD;

   bsc_alu #(.UW(UW)) u_alu (
      .op      (alu_op),
      .a       (work_ff[q_ff]),
      .b       ((state_ff == ST_CHECK) ? rd_need : rd_alloc),
      .less    (alu_less),
      .sat_sum (alu_sum)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_accept) state_in = ST_COPY;
         end
         ST_COPY: begin
            if (q_ff == RW'(MAX_RES - 1)) state_in = ST_PROC;
         end
         ST_PROC: begin
            priority if (all_done)            state_in = ST_VERDICT;
            else if (done_ff[p_ff])           state_in = ST_NEXT;
            else if (r_eff == '0)             state_in = ST_NEXT;
            else                              state_in = ST_CHECK_RD;
         end
         ST_CHECK_RD: state_in = ST_CHECK;
         ST_CHECK: begin
            priority if (alu_less) state_in = ST_NEXT;
            else if (q_last)       state_in = ST_GRANT_RD;
            else                   state_in = ST_CHECK_RD;
         end
         ST_GRANT_RD: state_in = ST_GRANT;
         ST_GRANT: begin
            state_in = q_last ? ST_NEXT : ST_GRANT_RD;
         end
         ST_NEXT: begin
            if (p_last) state_in = pass_ff ? ST_PROC : ST_VERDICT;
            else        state_in = ST_PROC;
         end
         ST_VERDICT: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      p_in         = p_ff;
      q_in         = q_ff;
      granted_in   = granted_ff;
      pass_in      = pass_ff;
      done_in      = done_ff;
      work_we      = 1'b0;
      work_wdata   = alu_sum;
      emit_grant   = 1'b0;
      emit_verdict = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_accept) begin
               q_in       = '0;
               done_in    = '0;
               granted_in = '0;
            end
         end
         ST_COPY: begin
            work_we    = 1'b1;
            work_wdata = avail_ff[q_ff];
            if (q_ff == RW'(MAX_RES - 1)) begin
               q_in    = '0;
               p_in    = '0;
               pass_in = 1'b0;
            end else begin
               q_in = q_ff + RW'(1);
            end
         end
         ST_PROC: begin
            q_in = '0;
            // With no resources in use every waiting process fits at once.
            if (!all_done && !done_ff[p_ff] && r_eff == '0) begin
               emit_grant    = 1'b1;
               done_in[p_ff] = 1'b1;
               granted_in    = granted_ff + NW'(1);
               pass_in       = 1'b1;
            end
         end
         ST_CHECK_RD: rd_en = 1'b1;
         ST_CHECK: begin
            if (!alu_less) begin
               if (q_last) begin
                  emit_grant    = 1'b1;
                  done_in[p_ff] = 1'b1;
                  granted_in    = granted_ff + NW'(1);
                  pass_in       = 1'b1;
                  q_in          = '0;
               end else begin
                  q_in = q_ff + RW'(1);
               end
            end
         end
         ST_GRANT_RD: rd_en = 1'b1;
         ST_GRANT: begin
            work_we = 1'b1;
            q_in    = q_last ? '0 : q_ff + RW'(1);
         end
         ST_NEXT: begin
            if (p_last) begin
               p_in    = '0;
               pass_in = 1'b0;
            end else begin
               p_in = p_ff + PW'(1);
            end
         end
         ST_VERDICT: emit_verdict = 1'b1;
         default: ;
      endcase
   end

   assign rd_addr = AW'(int'(p_ff) * MAX_RES + int'(q_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_ff         <= '0;
         q_ff         <= '0;
         granted_ff   <= '0;
         pass_ff      <= 1'b0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         q_ff         <= q_in;
         granted_ff   <= granted_in;
         pass_ff      <= pass_in;
         done_ff      <= done_in;
         rsp_valid_ff <= emit_grant | emit_verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_ff[q_ff] <= work_wdata;
      end
      if (avail_we) begin
         avail_ff[RW'(avail_idx)] <= avail_val;
      end
      rsp_ff.process_id  <= emit_verdict ? '0 : PID_W'(p_ff);
      rsp_ff.is_verdict  <= emit_verdict;
      rsp_ff.system_safe <= emit_verdict & all_done;
      rsp_ff.last        <= emit_verdict;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_verdict_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_verdict |-> state_ff == ST_IDLE)
      else $error("verdict transferred while the run is still going");

   a_grant_marked_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_verdict |-> done_ff[p_ff])
      else $error("grant transferred for a process not marked done");

   a_granted_bounded: assert property (@(posedge clock) disable iff (reset)
      busy && state_ff != ST_COPY |-> granted_ff <= n_eff)
      else $error("more grants than processes");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      run_accept && !busy |=> state_ff == ST_COPY && done_ff == '0)
      else $error("run did not start with cleared done marks");

endmodule

`default_nettype wire

// ----- hw/rtl/bankers_safety_check_unit.sv -----
// Top level of the Banker's algorithm safety check: register port, item
// decode and the table memory. Depends on bsc_pkg, bsc_table and bsc_seq.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_*                      start high while busy low
//   result    rsp_valid, rsp_*                        rsp_valid high, one cycle
//   registers csr_write_enable, csr_index, csr_*      csr_write_enable high
//
// A load item gives no result; busy stays low.
// A run first copies the availability into the working vector, then visits
// each process in turn: it compares the need with the working vector one
// resource at a time (one memory read port), adds the allocation back on a
// grant, and ends in the verdict once all are granted or a pass grants none.
// Each result is on rsp_* for one cycle, in the cycle after it is produced.
// Reset clears the control state; the tables hold garbage until written.
// The receiver cannot hold results off.
`timescale 1ns / 1ps
`default_nettype none

module bankers_safety_check_unit #(
   parameter int MAX_PROCS  = 16,
   parameter int MAX_RES    = 10,
   parameter int UNIT_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire bsc_pkg::op_type       req_operation,
   input  wire logic [3:0]            req_process_index,
   input  wire logic [3:0]            req_resource_index,
   input  wire logic [15:0]           req_allocated_units,
   input  wire logic [15:0]           req_maximum_units,
   input  wire logic [15:0]           req_available_units,
   output logic                       rsp_valid,
   output logic [bsc_pkg::PID_W-1:0]  rsp_process_id,
   output logic                       rsp_is_verdict,
   output logic                       rsp_system_safe,
   output logic                       rsp_last,
   input  wire logic                  csr_write_enable,
   input  wire bsc_pkg::csr_idx_type  csr_index,
   input  wire logic [4:0]            csr_write_data
);
   import bsc_pkg::*;

   localparam int UW    = UNIT_WIDTH;
   localparam int DEPTH = MAX_PROCS * MAX_RES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(MAX_PROCS + 1);
   localparam int RCW   = $clog2(MAX_RES + 1);

   logic [4:0]     num_processes_ff;
   logic [3:0]     num_resources_ff;
   logic [NW-1:0]  n_eff;
   logic [RCW-1:0] r_eff;
   logic           accept;
   logic           proc_in_range, res_in_range;
   logic           tbl_we;
   logic [AW-1:0]  tbl_wr_addr;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [UW-1:0]  rd_alloc, rd_need;
   rsp_type        rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_processes_ff <= 5'd1;
         num_resources_ff <= 4'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NUM_PROCESSES: num_processes_ff <= csr_write_data;
            CSR_NUM_RESOURCES: num_resources_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Register values beyond the table size count as the table size.
   assign n_eff = (int'(num_processes_ff) > MAX_PROCS) ? NW'(MAX_PROCS)
                                                       : NW'(num_processes_ff);
   assign r_eff = (int'(num_resources_ff) > MAX_RES) ? RCW'(MAX_RES)
                                                     : RCW'(num_resources_ff);

   assign accept        = start & ~busy;
   assign proc_in_range = int'(req_process_index) < MAX_PROCS;
   assign res_in_range  = int'(req_resource_index) < MAX_RES;
   assign tbl_we        = accept && req_operation == OP_LOAD_PROC
                          && proc_in_range && res_in_range;
   assign tbl_wr_addr   = AW'(int'(req_process_index) * MAX_RES
                              + int'(req_resource_index));

   bsc_table #(.UW(UW), .DEPTH(DEPTH), .AW(AW)) u_table (
      .clock    (clock),
      .wr_en    (tbl_we),
      .wr_addr  (tbl_wr_addr),
      .wr_alloc (UW'(req_allocated_units)),
      .wr_max   (UW'(req_maximum_units)),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_alloc (rd_alloc),
      .rd_need  (rd_need)
   );

   bsc_seq #(
      .MAX_PROCS (MAX_PROCS),
      .MAX_RES   (MAX_RES),
      .UW        (UW),
      .AW        (AW),
      .NW        (NW),
      .RCW       (RCW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .run_accept (accept && req_operation == OP_RUN),
      .avail_we   (accept && req_operation == OP_LOAD_AVAIL && res_in_range),
      .avail_idx  (req_resource_index),
      .avail_val  (UW'(req_available_units)),
      .n_eff      (n_eff),
      .r_eff      (r_eff),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_alloc   (rd_alloc),
      .rd_need    (rd_need),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_process_id  = rsp.process_id;
   assign rsp_is_verdict  = rsp.is_verdict;
   assign rsp_system_safe = rsp.system_safe;
   assign rsp_last        = rsp.last;

endmodule

`default_nettype wire
